@@ hw/rtl/neuron_weighted_sum_activation_unit_macros.svh @@
// Assertion macros shared by the neuron weighted sum RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef NEURON_WEIGHTED_SUM_ACTIVATION_UNIT_MACROS_SVH
`define NEURON_WEIGHTED_SUM_ACTIVATION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NWSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NWSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nwsa_pkg.sv @@
// Shared types and constants for the neuron weighted sum unit.
// No dependencies.
package nwsa_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC       = DATA_WIDTH - 4;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int MODE_WIDTH = 3;

    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TERM,
        KIND_LAST,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] source_activation;
        logic signed [DATA_WIDTH-1:0] weight;
        logic                         last_term;
        logic                         empty_req;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] activation;
        logic                         saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [PROD_WIDTH-1:0] product;
        kind_t                        kind;
    } mid_item_t;

endpackage

@@ hw/rtl/nwsa_fifo.sv @@
// Small first-in first-out queue with the head visible combinationally.
// No package dependencies.
module nwsa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    output logic [WIDTH-1:0]               rd_data,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

@@ hw/rtl/nwsa_front.sv @@
// Front end: accepts input requests, forms the product and classifies the item.
// Depends on nwsa_pkg.
module nwsa_front
    import nwsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             in_data,
    input  logic [MID_CNT_W-1:0] mid_count,
    output logic                 full,
    output logic                 mid_wr,
    output mid_item_t            mid_item
);

    logic                         valid_reg;
    logic signed [PROD_WIDTH-1:0] product_reg;
    kind_t                        kind_reg;
    logic                         accept;
    kind_t                        kind_next;

    // Count the item held here against the queue so it always finds room.
    assign full   = ((MID_CNT_W + 1)'(mid_count) + (MID_CNT_W + 1)'(valid_reg))
                    >= (MID_CNT_W + 1)'(MID_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        if (in_data.empty_req)
        begin
            kind_next = KIND_EMPTY;
        end
        else if (in_data.last_term)
        begin
            kind_next = KIND_LAST;
        end
        else
        begin
            kind_next = KIND_TERM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            product_reg <= in_data.source_activation * in_data.weight;
            kind_reg    <= kind_next;
        end
    end

    assign mid_wr           = valid_reg;
    assign mid_item.product = product_reg;
    assign mid_item.kind    = kind_reg;

endmodule

@@ hw/rtl/nwsa_back.sv @@
// Back end: accumulates products, rounds and clips the sum, applies the activation.
// Depends on nwsa_pkg and the assertion macro header.
`include "neuron_weighted_sum_activation_unit_macros.svh"

module nwsa_back
    import nwsa_pkg::*;
#(
    parameter int ACC_WIDTH = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [MODE_WIDTH-1:0] cfg_wr_data,
    input  mid_item_t             mid_item,
    input  logic [MID_CNT_W-1:0]  mid_count,
    output logic                  mid_rd,
    input  logic [OUT_CNT_W-1:0]  out_count,
    output logic                  res_wr,
    output out_item_t             res_item
);

    localparam int SUM_W = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - 1;
    localparam logic signed [ACC_WIDTH:0] DATA_MAX =
        {{(ACC_WIDTH + 2 - DATA_WIDTH){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_WIDTH:0] DATA_MIN = -DATA_MAX - 1;

    localparam logic [MODE_WIDTH-1:0] MODE_SIGMOID = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_RELU    = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_TANH    = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_SOFTMAX = 3'd4;

    localparam int ONE         = 1 << FRAC;
    localparam int SIG_SAT_TH  = 5 * ONE;
    localparam int SIG_MID_TH  = (19 * ONE) >> 3;
    localparam int SIG_HI_OFS  = (27 * ONE) >> 5;
    localparam int SIG_MID_OFS = (5 * ONE) >> 3;
    localparam int SIG_LO_OFS  = ONE >> 1;

    // Piecewise sigmoid of a non-negative magnitude; result never exceeds one.
    function automatic logic [FRAC:0] sigmoid_mag(input logic [DATA_WIDTH:0] a);
        logic [DATA_WIDTH:0] y;
        if (a >= (DATA_WIDTH + 1)'(SIG_SAT_TH))
        begin
            y = (DATA_WIDTH + 1)'(ONE);
        end
        else if (a >= (DATA_WIDTH + 1)'(SIG_MID_TH))
        begin
            y = (a >> 5) + (DATA_WIDTH + 1)'(SIG_HI_OFS);
        end
        else if (a >= (DATA_WIDTH + 1)'(ONE))
        begin
            y = (a >> 3) + (DATA_WIDTH + 1)'(SIG_MID_OFS);
        end
        else
        begin
            y = (a >> 2) + (DATA_WIDTH + 1)'(SIG_LO_OFS);
        end
        return y[FRAC:0];
    endfunction

    logic [MODE_WIDTH-1:0]        mode_reg;
    logic signed [ACC_WIDTH-1:0]  acc_sum_reg;
    logic                         acc_clip_reg;
    logic signed [ACC_WIDTH-1:0]  acc_sum_next;
    logic                         acc_clip_next;
    logic                         fin_valid_reg;
    logic signed [ACC_WIDTH-1:0]  fin_sum_reg;
    logic                         fin_clip_reg;
    logic signed [ACC_WIDTH-1:0]  fin_sum_next;
    logic                         fin_clip_next;
    logic                         x_valid_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic                         x_sat_reg;
    logic signed [DATA_WIDTH-1:0] x_next;
    logic                         x_sat_next;

    logic                         mid_avail;
    logic                         is_result;
    logic                         credit_ok;
    logic                         issue;
    logic signed [SUM_W-1:0]      sum_ext;
    logic signed [SUM_W-1:0]      prod_ext;
    logic signed [SUM_W-1:0]      sum_wide;
    logic signed [ACC_WIDTH-1:0]  add_sum;
    logic                         add_clip;
    logic signed [ACC_WIDTH-1:0]  shifted;
    logic signed [ACC_WIDTH:0]    rounded;
    logic                         x_neg;
    logic [DATA_WIDTH-1:0]        mag;
    logic [FRAC:0]                sig;
    logic [FRAC:0]                tsig;
    logic [DATA_WIDTH-1:0]        tanh_pos;
    logic signed [DATA_WIDTH-1:0] act;

    // Hold back a result until the output queue has a free slot for it.
    assign mid_avail = (mid_count != '0);
    assign is_result = (mid_item.kind == KIND_LAST) || (mid_item.kind == KIND_EMPTY);
    assign credit_ok = ((OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(fin_valid_reg)
                        + (OUT_CNT_W + 1)'(x_valid_reg)) < (OUT_CNT_W + 1)'(OUT_DEPTH);
    assign mid_rd    = mid_avail && (!is_result || credit_ok);
    assign issue     = mid_rd && is_result;

    // Saturating accumulate
    always_comb
    begin
        sum_ext  = {{(SUM_W - ACC_WIDTH){acc_sum_reg[ACC_WIDTH-1]}}, acc_sum_reg};
        prod_ext = {{(SUM_W - PROD_WIDTH){mid_item.product[PROD_WIDTH-1]}}, mid_item.product};
        sum_wide = sum_ext + prod_ext;
        add_clip = acc_clip_reg;
        if (sum_wide > ACC_MAX)
        begin
            add_sum  = ACC_MAX[ACC_WIDTH-1:0];
            add_clip = 1'b1;
        end
        else if (sum_wide < ACC_MIN)
        begin
            add_sum  = ACC_MIN[ACC_WIDTH-1:0];
            add_clip = 1'b1;
        end
        else
        begin
            add_sum = sum_wide[ACC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        acc_sum_next  = acc_sum_reg;
        acc_clip_next = acc_clip_reg;
        fin_sum_next  = add_sum;
        fin_clip_next = add_clip;
        // An empty neuron drops any partial sum and activates zero.
        if (mid_item.kind == KIND_EMPTY)
        begin
            fin_sum_next  = '0;
            fin_clip_next = 1'b0;
        end
        if (issue)
        begin
            acc_sum_next  = '0;
            acc_clip_next = 1'b0;
        end
        else if (mid_rd)
        begin
            acc_sum_next  = add_sum;
            acc_clip_next = add_clip;
        end
    end

    // Round half up to the data format, then clip
    always_comb
    begin
        shifted    = fin_sum_reg >>> FRAC;
        rounded    = {shifted[ACC_WIDTH-1], shifted}
                     + {{ACC_WIDTH{1'b0}}, fin_sum_reg[FRAC-1]};
        x_sat_next = fin_clip_reg;
        if (rounded > DATA_MAX)
        begin
            x_next     = DATA_MAX[DATA_WIDTH-1:0];
            x_sat_next = 1'b1;
        end
        else if (rounded < DATA_MIN)
        begin
            x_next     = DATA_MIN[DATA_WIDTH-1:0];
            x_sat_next = 1'b1;
        end
        else
        begin
            x_next = rounded[DATA_WIDTH-1:0];
        end
    end

    // Activation
    always_comb
    begin
        x_neg    = x_reg[DATA_WIDTH-1];
        mag      = x_neg ? (~x_reg + 1'b1) : x_reg;
        sig      = sigmoid_mag({1'b0, mag});
        tsig     = sigmoid_mag({mag, 1'b0});
        tanh_pos = DATA_WIDTH'({tsig, 1'b0}) - DATA_WIDTH'(ONE);
        case (mode_reg)
            MODE_SIGMOID, MODE_SOFTMAX:
            begin
                act = x_neg ? (DATA_WIDTH'(ONE) - DATA_WIDTH'(sig)) : DATA_WIDTH'(sig);
            end
            MODE_RELU:
            begin
                act = (x_reg > 0) ? x_reg : '0;
            end
            MODE_TANH:
            begin
                act = x_neg ? (~tanh_pos + 1'b1) : tanh_pos;
            end
            default:
            begin
                act = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SIGMOID;
            acc_sum_reg   <= '0;
            acc_clip_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            x_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            acc_sum_reg   <= acc_sum_next;
            acc_clip_reg  <= acc_clip_next;
            fin_valid_reg <= issue;
            x_valid_reg   <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            fin_sum_reg  <= fin_sum_next;
            fin_clip_reg <= fin_clip_next;
        end
        if (fin_valid_reg)
        begin
            x_reg     <= x_next;
            x_sat_reg <= x_sat_next;
        end
    end

    assign res_wr              = x_valid_reg;
    assign res_item.activation = act;
    assign res_item.saturated  = x_sat_reg;

    `NWSA_ASSERT_IMPLY(a_no_read_empty, mid_rd, mid_count != '0, "read from empty mid queue")
    `NWSA_ASSERT_IMPLY(a_out_room, res_wr, out_count < OUT_CNT_W'(OUT_DEPTH), "output queue overrun")
    `NWSA_ASSERT_NEXT(a_acc_cleared, issue, (acc_sum_reg == '0) && !acc_clip_reg, "sum not cleared")
    `NWSA_ASSERT_NEXT(a_stage_follow, fin_valid_reg, x_valid_reg, "result lost between stages")

endmodule

@@ hw/rtl/neuron_weighted_sum_activation_unit.sv @@
// Neuron weighted sum with activation: top level with queue-style ports.
// Depends on nwsa_pkg, nwsa_front, nwsa_fifo and nwsa_back.
//
// Each request carries one (source_activation, weight) term in signed Q4.12; terms
// are multiplied and summed into an ACC_WIDTH-bit saturating accumulator, and the term
// flagged last_term (or any request flagged empty_req, which discards the partial sum
// and activates zero) yields one result: the sum rounded half up to Q4.12, clipped,
// and passed through the activation chosen by the mode register (0 sigmoid, 1 relu,
// 2 tanh, 3 linear, 4 sigmoid, 5 to 7 pass through). One term is accepted per clock
// while full is low, set by the single 16x16 multiplier and the one accumulator add per
// cycle. A result passes through the product register, mid queue, accumulator, rounding
// register and output queue in that order. The output queue holds four results; with it
// full the back end stops on the next result request, and full rises once the mid queue
// (four entries) and product register hold four. Write the mode only while idle.
module neuron_weighted_sum_activation_unit
    import nwsa_pkg::*;
#(
    parameter int ACC_WIDTH = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_item_t              in_data,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [MODE_WIDTH-1:0] cfg_wr_data
);

    logic                 mid_wr;
    mid_item_t            mid_wr_item;
    mid_item_t            mid_rd_item;
    logic                 mid_rd;
    logic [MID_CNT_W-1:0] mid_count;
    logic                 res_wr;
    out_item_t            res_item;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_rd;

    nwsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_data   (in_data),
        .mid_count (mid_count),
        .full      (full),
        .mid_wr    (mid_wr),
        .mid_item  (mid_wr_item)
    );

    nwsa_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wr_item),
        .rd_en   (mid_rd),
        .rd_data (mid_rd_item),
        .count   (mid_count)
    );

    nwsa_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mid_item    (mid_rd_item),
        .mid_count   (mid_count),
        .mid_rd      (mid_rd),
        .out_count   (out_count),
        .res_wr      (res_wr),
        .res_item    (res_item)
    );

    assign empty  = (out_count == '0);
    assign out_rd = pop && !empty;

    nwsa_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_item),
        .rd_en   (out_rd),
        .rd_data (out_data),
        .count   (out_count)
    );

endmodule
